/* rtl/clcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the character LCD 4-bit bus sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    // Request codes carried by each input tick.
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_INIT    = 2'd1,
        CMD_WR_CMD  = 2'd2,
        CMD_WR_CHAR = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_POWERUP_WAIT = 3'd0,
        REG_WAIT_FIRST   = 3'd1,
        REG_WAIT_SECOND  = 3'd2,
        REG_INSTR_WAIT   = 3'd3,
        REG_CLEAR_WAIT   = 3'd4,
        REG_FUNC_SET     = 3'd5,
        REG_DISP_CTRL    = 3'd6,
        REG_ENTRY_MODE   = 3'd7
    } t_reg_idx;

    // Sequencer phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_WAIT  = 4'b0010,
        PH_EHIGH = 4'b0100,
        PH_ELOW  = 4'b1000
    } t_phase;

    // Initialization steps; step zero means a plain byte transfer.
    localparam logic [3:0] STEP_BYTE      = 4'd0;
    localparam logic [3:0] STEP_PWR_WAIT  = 4'd1;
    localparam logic [3:0] STEP_NIB_A     = 4'd2;
    localparam logic [3:0] STEP_WAIT_A    = 4'd3;
    localparam logic [3:0] STEP_NIB_B     = 4'd4;
    localparam logic [3:0] STEP_WAIT_B    = 4'd5;
    localparam logic [3:0] STEP_NIB_C     = 4'd6;
    localparam logic [3:0] STEP_WAIT_C    = 4'd7;
    localparam logic [3:0] STEP_NIB_D     = 4'd8;
    localparam logic [3:0] STEP_WAIT_D    = 4'd9;
    localparam logic [3:0] STEP_FUNC_SET  = 4'd10;
    localparam logic [3:0] STEP_DISP_CTRL = 4'd11;
    localparam logic [3:0] STEP_CLEAR     = 4'd12;
    localparam logic [3:0] STEP_CLR_WAIT  = 4'd13;
    localparam logic [3:0] STEP_ENTRY     = 4'd14;
    localparam logic [3:0] STEP_DONE      = 4'd15;

    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;
    localparam logic [7:0] CLEAR_BYTE = 8'h01;

    // Configuration reset values.
    localparam logic [19:0] RST_POWERUP_WAIT = 20'd116000;
    localparam logic [19:0] RST_WAIT_FIRST   = 20'd5000;
    localparam logic [19:0] RST_WAIT_SECOND  = 20'd100;
    localparam logic [19:0] RST_INSTR_WAIT   = 20'd42;
    localparam logic [19:0] RST_CLEAR_WAIT   = 20'd1520;
    localparam logic [7:0]  RST_FUNC_SET     = 8'h28;
    localparam logic [7:0]  RST_DISP_CTRL    = 8'h0C;
    localparam logic [7:0]  RST_ENTRY_MODE   = 8'h06;

    typedef struct packed {
        logic [19:0] powerup_wait;
        logic [19:0] wait_after_first;
        logic [19:0] wait_after_second;
        logic [19:0] instr_wait;
        logic [19:0] clear_wait;
        logic [7:0]  function_set_word;
        logic [7:0]  display_control_word;
        logic [7:0]  entry_mode_word;
    } t_cfg;

    // One result per tick.
    typedef struct packed {
        logic       pin_enable;
        logic       pin_select;
        logic       pin_readwrite;
        logic [3:0] pin_data;
        logic       busy_res;
        logic       accepted;
    } t_result;

endpackage

/* rtl/clcd_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_in_if
// Request channel: one tick per transfer, with an optional request.
// ----------------------------------------------------------------------------
interface clcd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

/* rtl/clcd_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_out_if
// Result channel: LCD pin levels and status for one tick per transfer.
// ----------------------------------------------------------------------------
interface clcd_out_if;
    logic       valid;
    logic       ready;
    logic       pin_enable;
    logic       pin_select;
    logic       pin_readwrite;
    logic [3:0] pin_data;
    logic       busy_res;
    logic       accepted;

    modport source (output valid, output pin_enable, output pin_select,
                    output pin_readwrite, output pin_data, output busy_res,
                    output accepted, input ready);
    modport sink   (input valid, input pin_enable, input pin_select,
                    input pin_readwrite, input pin_data, input busy_res,
                    input accepted, output ready);
endinterface

/* rtl/char_lcd_4bit_interface_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_sequencer_core
// Character LCD controller for the 4-bit bus: init sequence and byte writes.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on i_in is one timing tick (normally one microsecond) and
//   may carry a request: start the init sequence, write a command byte, or
//   write a character byte. For every tick one transfer leaves on o_out with
//   the enable, RS, RW and D4..D7 levels, the busy flag and whether the
//   request was taken. A request made while busy is refused (accepted low).
//   Waits and init bytes are set through the APB registers, which the user
//   must write while the sequencer is idle; the block does not enforce it.
// Timing:
//   A tick passes an input register and then the result register before
//   its result is on o_out. One tick is taken every cycle while the result
//   register can drain to o_out; the next-state logic settles one tick in
//   a single combinational pass.
// Reset and stalls:
//   Reset returns the sequencer to idle with RS and data low and loads the
//   default register values. When o_out.ready is low the result holds, and
//   i_in.ready drops once the input register is also full; no tick is lost.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_sequencer_core
    import clcd_pkg::*;
#(
    parameter int WAIT_BITS          = 20,
    parameter int ENABLE_PULSE_TICKS = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    clcd_in_if.sink      i_in,
    clcd_out_if.source   o_out
);

    t_cfg       w_cfg;
    t_result    w_res;
    logic       w_adv;

    logic       r_in_vld;
    logic [1:0] r_cmd;
    logic [7:0] r_val;
    logic       r_out_vld;
    t_result    r_res;

    clcd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    clcd_engine #(
        .WAIT_BITS          (WAIT_BITS),
        .ENABLE_PULSE_TICKS (ENABLE_PULSE_TICKS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_command (r_cmd),
        .i_value   (r_val),
        .i_cfg     (w_cfg),
        .o_result  (w_res)
    );

    // A held tick is processed when the result register can take its result.
    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= i_in.command;
            r_val <= i_in.value;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.pin_enable    = r_res.pin_enable;
    assign o_out.pin_select    = r_res.pin_select;
    assign o_out.pin_readwrite = r_res.pin_readwrite;
    assign o_out.pin_data      = r_res.pin_data;
    assign o_out.busy_res      = r_res.busy_res;
    assign o_out.accepted      = r_res.accepted;

endmodule

/* rtl/clcd_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_cfg_regs
// APB-style register file holding the wait lengths and init command bytes.
// ----------------------------------------------------------------------------
module clcd_cfg_regs
    import clcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes complete in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.powerup_wait         <= RST_POWERUP_WAIT;
            r_cfg.wait_after_first     <= RST_WAIT_FIRST;
            r_cfg.wait_after_second    <= RST_WAIT_SECOND;
            r_cfg.instr_wait           <= RST_INSTR_WAIT;
            r_cfg.clear_wait           <= RST_CLEAR_WAIT;
            r_cfg.function_set_word    <= RST_FUNC_SET;
            r_cfg.display_control_word <= RST_DISP_CTRL;
            r_cfg.entry_mode_word      <= RST_ENTRY_MODE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POWERUP_WAIT: r_cfg.powerup_wait         <= pwdata[19:0];
                REG_WAIT_FIRST:   r_cfg.wait_after_first     <= pwdata[19:0];
                REG_WAIT_SECOND:  r_cfg.wait_after_second    <= pwdata[19:0];
                REG_INSTR_WAIT:   r_cfg.instr_wait           <= pwdata[19:0];
                REG_CLEAR_WAIT:   r_cfg.clear_wait           <= pwdata[19:0];
                REG_FUNC_SET:     r_cfg.function_set_word    <= pwdata[7:0];
                REG_DISP_CTRL:    r_cfg.display_control_word <= pwdata[7:0];
                REG_ENTRY_MODE:   r_cfg.entry_mode_word      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero extended.
    always_comb begin
        unique case (w_idx)
            REG_POWERUP_WAIT: prdata = {12'd0, r_cfg.powerup_wait};
            REG_WAIT_FIRST:   prdata = {12'd0, r_cfg.wait_after_first};
            REG_WAIT_SECOND:  prdata = {12'd0, r_cfg.wait_after_second};
            REG_INSTR_WAIT:   prdata = {12'd0, r_cfg.instr_wait};
            REG_CLEAR_WAIT:   prdata = {12'd0, r_cfg.clear_wait};
            REG_FUNC_SET:     prdata = {24'd0, r_cfg.function_set_word};
            REG_DISP_CTRL:    prdata = {24'd0, r_cfg.display_control_word};
            REG_ENTRY_MODE:   prdata = {24'd0, r_cfg.entry_mode_word};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/clcd_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_engine
// Sequencer state and the single-pass next-state logic for one tick.
// ----------------------------------------------------------------------------
module clcd_engine
    import clcd_pkg::*;
#(
    parameter int WAIT_BITS          = 20,
    parameter int ENABLE_PULSE_TICKS = 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_command,
    input  logic [7:0] i_value,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int CW = (WAIT_BITS > 20) ? WAIT_BITS : 20;
    localparam logic [CW-1:0] WAIT_MAX_EXT = CW'((64'd1 << WAIT_BITS) - 64'd1);
    localparam logic [WAIT_BITS-1:0] PULSE = WAIT_BITS'(ENABLE_PULSE_TICKS);

    typedef struct packed {
        t_phase               phase;
        logic [3:0]           init_step;
        logic [WAIT_BITS-1:0] wait_count;
        logic [7:0]           held_byte;
        logic                 second_nibble;
        logic                 select_level;
        logic [3:0]           data_lines;
    } t_seq_state;

    t_seq_state r_st;
    t_seq_state n_st;
    t_cmd       w_cmd;

    assign w_cmd = t_cmd'(i_command);

    // Clamp a configured wait to what the counter can hold.
    function automatic logic [WAIT_BITS-1:0] sat_wait(input logic [19:0] n);
        logic [CW-1:0] ext;
        ext = CW'(n);
        if (ext > WAIT_MAX_EXT) begin
            return WAIT_BITS'(WAIT_MAX_EXT);
        end
        return WAIT_BITS'(ext);
    endfunction

    function automatic logic step_is_byte(input logic [3:0] s);
        return (s == STEP_BYTE) || (s == STEP_FUNC_SET) || (s == STEP_DISP_CTRL) ||
               (s == STEP_CLEAR) || (s == STEP_ENTRY);
    endfunction

    function automatic t_seq_state start_pulse(input t_seq_state st);
        t_seq_state r;
        r            = st;
        r.phase      = PH_EHIGH;
        r.wait_count = PULSE;
        return r;
    endfunction

    function automatic t_seq_state start_byte(input t_seq_state st, input logic [7:0] b);
        t_seq_state r;
        r               = st;
        r.held_byte     = b;
        r.second_nibble = 1'b0;
        r.data_lines    = b[7:4];
        return start_pulse(r);
    endfunction

    // Steps that drive the bus: single init nibbles and init bytes.
    function automatic t_seq_state do_action(input t_seq_state st, input logic [3:0] s,
                                             input t_cfg cfg);
        t_seq_state r;
        r              = st;
        r.init_step    = s;
        r.select_level = 1'b0;
        if (s == STEP_NIB_A || s == STEP_NIB_B || s == STEP_NIB_C) begin
            r.data_lines = NIB_WAKE;
            r = start_pulse(r);
        end else if (s == STEP_NIB_D) begin
            r.data_lines = NIB_4BIT;
            r = start_pulse(r);
        end else if (s == STEP_FUNC_SET) begin
            r = start_byte(r, cfg.function_set_word);
        end else if (s == STEP_DISP_CTRL) begin
            r = start_byte(r, cfg.display_control_word);
        end else if (s == STEP_CLEAR) begin
            r = start_byte(r, CLEAR_BYTE);
        end else begin
            r = start_byte(r, cfg.entry_mode_word);
        end
        return r;
    endfunction

    // Enter an init step; a zero wait falls straight through to the next step.
    function automatic t_seq_state begin_step(input t_seq_state st, input logic [3:0] s,
                                              input t_cfg cfg);
        t_seq_state  r;
        logic [19:0] n;
        logic        is_wait;
        r       = st;
        n       = 20'd0;
        is_wait = 1'b1;
        if (s == STEP_DONE) begin
            r.init_step  = STEP_BYTE;
            r.phase      = PH_IDLE;
            r.wait_count = '0;
            return r;
        end
        if (s == STEP_PWR_WAIT) begin
            n = cfg.powerup_wait;
        end else if (s == STEP_WAIT_A) begin
            n = cfg.wait_after_first;
        end else if (s == STEP_WAIT_B) begin
            n = cfg.wait_after_second;
        end else if (s == STEP_WAIT_C || s == STEP_WAIT_D) begin
            n = cfg.instr_wait;
        end else if (s == STEP_CLR_WAIT) begin
            n = cfg.clear_wait;
        end else begin
            is_wait = 1'b0;
        end
        if (!is_wait) begin
            return do_action(r, s, cfg);
        end
        r.init_step = s;
        if (n != 20'd0) begin
            r.phase      = PH_WAIT;
            r.wait_count = sat_wait(n);
            return r;
        end
        return do_action(r, s + 4'd1, cfg);
    endfunction

    function automatic t_seq_state after_wait(input t_seq_state st, input t_cfg cfg);
        t_seq_state r;
        r = st;
        if (r.init_step == STEP_BYTE) begin
            r.phase      = PH_IDLE;
            r.wait_count = '0;
            return r;
        end
        return begin_step(r, r.init_step + 4'd1, cfg);
    endfunction

    // End of the current phase: next pulse half, next nibble, wait or step.
    function automatic t_seq_state phase_done(input t_seq_state st, input t_cfg cfg);
        t_seq_state r;
        r = st;
        unique case (r.phase)
            PH_EHIGH: begin
                r.phase      = PH_ELOW;
                r.wait_count = PULSE;
            end
            PH_ELOW: begin
                if (step_is_byte(r.init_step)) begin
                    if (!r.second_nibble) begin
                        r.second_nibble = 1'b1;
                        r.data_lines    = r.held_byte[3:0];
                        r = start_pulse(r);
                    end else if (cfg.instr_wait == 20'd0) begin
                        r = after_wait(r, cfg);
                    end else begin
                        r.phase      = PH_WAIT;
                        r.wait_count = sat_wait(cfg.instr_wait);
                    end
                end else begin
                    r = begin_step(r, r.init_step + 4'd1, cfg);
                end
            end
            PH_WAIT:  r = after_wait(r, cfg);
            default:  ;
        endcase
        return r;
    endfunction

    // One tick: take a request if idle, drive pins, then count down.
    always_comb begin
        t_seq_state s;
        logic       acc;
        s   = r_st;
        acc = 1'b0;
        if (w_cmd != CMD_TICK && s.phase == PH_IDLE) begin
            acc = 1'b1;
            if (w_cmd == CMD_INIT) begin
                s.select_level = 1'b0;
                s.data_lines   = 4'd0;
                s = begin_step(s, STEP_PWR_WAIT, i_cfg);
            end else begin
                s.init_step    = STEP_BYTE;
                s.select_level = (w_cmd == CMD_WR_CHAR);
                s = start_byte(s, i_value);
            end
        end

        o_result.pin_enable    = (s.phase == PH_EHIGH);
        o_result.pin_select    = s.select_level;
        o_result.pin_readwrite = 1'b0;
        o_result.pin_data      = s.data_lines;
        o_result.busy_res      = (s.phase != PH_IDLE);
        o_result.accepted      = acc;

        if (s.phase != PH_IDLE) begin
            if (s.wait_count != '0) begin
                s.wait_count = s.wait_count - WAIT_BITS'(1);
            end
            if (s.wait_count == '0) begin
                s = phase_done(s, i_cfg);
            end
        end
        n_st = s;
    end

    // State advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase         <= PH_IDLE;
            r_st.init_step     <= STEP_BYTE;
            r_st.wait_count    <= '0;
            r_st.held_byte     <= 8'd0;
            r_st.second_nibble <= 1'b0;
            r_st.select_level  <= 1'b0;
            r_st.data_lines    <= 4'd0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

endmodule
